// ===== hdl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the max-heap queue
// Opcodes, internal command codes, status codes and the command queue entry.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int QDEPTH   = 2;

	localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_REMOVE,
		CMD_DROP_FULL,
		CMD_REMOVE_EMPTY
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_FINISH
	} eng_state_t;

endpackage

// ===== hdl/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hdl/bmhq_front.sv =====
// ----------------------------------------------------------------------------
// bmhq_front: input side of the heap queue
// Accept beats, classify them against a running element count, push commands.
// ----------------------------------------------------------------------------
module bmhq_front
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     q_full,
	output logic                     push,
	output item_t                    push_item
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] fcount_q;

	assign push = in_valid && !q_full;

	always_comb begin
		push_item.value = value;
		if (op == OP_REMOVE) begin
			push_item.cmd = (fcount_q == '0) ? CMD_REMOVE_EMPTY : CMD_REMOVE;
		end else begin
			push_item.cmd = (fcount_q >= CW'(CAPACITY)) ? CMD_DROP_FULL : CMD_INSERT;
		end
	end

	// track the count the back end will have once this command is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= '0;
		end else if (push) begin
			case (push_item.cmd)
				CMD_INSERT: fcount_q <= fcount_q + CW'(1);
				CMD_REMOVE: fcount_q <= fcount_q - CW'(1);
				default:    fcount_q <= fcount_q;
			endcase
		end
	end

endmodule

// ===== hdl/bmhq_fifo.sv =====
// ----------------------------------------------------------------------------
// bmhq_fifo: command queue between front and back end
// Small register queue; decouples input stalls from heap work.
// ----------------------------------------------------------------------------
module bmhq_fifo
	import bmhq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  q_valid,
	output item_t head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int NW = $clog2(QDEPTH + 1);

	item_t         slot_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] num_q;

	assign full    = (num_q == NW'(QDEPTH));
	assign q_valid = (num_q != '0);
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   num_q <= num_q + NW'(1);
				2'b01:   num_q <= num_q - NW'(1);
				default: num_q <= num_q;
			endcase
		end
	end

endmodule

// ===== hdl/bmhq_engine.sv =====
// ----------------------------------------------------------------------------
// bmhq_engine: heap back end
// Run sift-up and sift-down on the heap RAM and hold the result beat.
// ----------------------------------------------------------------------------
module bmhq_engine
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  item_t                     head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  removed_value,
	output logic signed [DATA_W-1:0]  top_value,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic [STATUS_W-1:0]       status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	eng_state_t               state_q, state_d;
	logic [AW-1:0]            pos_q;
	logic [CW-1:0]            cnt_q;
	logic signed [DATA_W-1:0] mov_q;
	logic signed [DATA_W-1:0] root_q;
	logic signed [DATA_W-1:0] removed_q;
	status_t                  stat_q;
	logic                     out_valid_q;

	logic                     we_c;
	logic [AW-1:0]            wa_c;
	logic signed [DATA_W-1:0] wd_c;
	logic [AW-1:0]            ra_c;
	logic [AW-1:0]            rb_c;
	logic [DATA_W-1:0]        rd_a_raw;
	logic [DATA_W-1:0]        rd_b_raw;
	logic signed [DATA_W-1:0] rd_a;
	logic signed [DATA_W-1:0] rd_b;
	logic                     res_load;

	logic [AW-1:0]            par_c;
	logic [IW-1:0]            lc_w;
	logic [IW-1:0]            rc_w;
	logic [IW-1:0]            cnt_w;
	logic                     lc_in;
	logic                     up_swap;
	logic                     take_l;
	logic                     take_r;
	logic signed [DATA_W-1:0] best1;

	bmhq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we_c),
		.waddr   (wa_c),
		.wdata   (wd_c),
		.raddr_a (ra_c),
		.rdata_a (rd_a_raw),
		.raddr_b (rb_c),
		.rdata_b (rd_b_raw)
	);

	assign rd_a = rd_a_raw;
	assign rd_b = rd_b_raw;

	assign par_c   = (pos_q - AW'(1)) >> 1;
	assign lc_w    = IW'({pos_q, 1'b1});
	assign rc_w    = lc_w + IW'(1);
	assign cnt_w   = IW'(cnt_q);
	assign lc_in   = lc_w < cnt_w;
	assign up_swap = rd_a < mov_q;
	assign take_l  = mov_q < rd_a;
	assign best1   = take_l ? rd_a : mov_q;
	assign take_r  = (rc_w < cnt_w) && (best1 < rd_b);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					case (head.cmd)
						CMD_INSERT: state_d = S_UP_RD;
						CMD_REMOVE: state_d = (cnt_q == CW'(1)) ? S_FINISH : S_DN_LAST;
						default:    state_d = S_FINISH;
					endcase
				end
			end
			S_UP_RD:   state_d = (pos_q == '0) ? S_FINISH : S_UP_CMP;
			S_UP_CMP:  state_d = up_swap ? S_UP_RD : S_FINISH;
			S_DN_LAST: state_d = S_DN_LOAD;
			S_DN_LOAD: state_d = S_DN_RD;
			S_DN_RD:   state_d = lc_in ? S_DN_CMP : S_FINISH;
			S_DN_CMP:  state_d = (take_l || take_r) ? S_DN_RD : S_FINISH;
			S_FINISH:  state_d = (!out_valid_q || !out_stall) ? S_IDLE : S_FINISH;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs: RAM control, queue pop, result load
	always_comb begin
		we_c     = 1'b0;
		wa_c     = pos_q;
		wd_c     = mov_q;
		ra_c     = par_c;
		rb_c     = rc_w[AW-1:0];
		pop      = 1'b0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE:  pop = q_valid;
			S_UP_RD: begin
				we_c = (pos_q == '0);
			end
			S_UP_CMP: begin
				we_c = 1'b1;
				wd_c = up_swap ? rd_a : mov_q;
			end
			S_DN_LAST: ra_c = cnt_q[AW-1:0];
			S_DN_RD: begin
				we_c = !lc_in;
				ra_c = lc_w[AW-1:0];
			end
			S_DN_CMP: begin
				we_c = 1'b1;
				if (take_r) begin
					wd_c = rd_b;
				end else if (take_l) begin
					wd_c = rd_a;
				end
			end
			S_FINISH: res_load = !out_valid_q || !out_stall;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && head.cmd == CMD_INSERT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && head.cmd == CMD_REMOVE) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (we_c && wa_c == '0) begin
			root_q <= wd_c;
		end
		case (state_q)
			S_IDLE: begin
				mov_q     <= head.value;
				pos_q     <= cnt_q[AW-1:0];
				removed_q <= (head.cmd == CMD_REMOVE) ? root_q : '0;
				case (head.cmd)
					CMD_DROP_FULL:    stat_q <= STAT_FULL;
					CMD_REMOVE_EMPTY: stat_q <= STAT_EMPTY;
					default:          stat_q <= STAT_OK;
				endcase
			end
			S_UP_CMP: begin
				if (up_swap) begin
					pos_q <= par_c;
				end
			end
			S_DN_LOAD: begin
				mov_q <= rd_a;
				pos_q <= '0;
			end
			S_DN_CMP: begin
				if (take_r) begin
					pos_q <= rc_w[AW-1:0];
				end else if (take_l) begin
					pos_q <= lc_w[AW-1:0];
				end
			end
			default: ;
		endcase
		if (res_load) begin
			removed_value <= removed_q;
			top_value     <= (cnt_q == '0) ? INT_MIN : root_q;
			count         <= COUNT_W'(cnt_q);
			is_empty      <= (cnt_q == '0);
			status        <= stat_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/binary_max_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit: priority queue on a binary max-heap
// Insert or remove-max per input beat; one result beat per input beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | op, value
//  output  | out_valid / out_stall| removed_value, top_value, count, is_empty,
//          |                      | status
//
// An insert alternates S_UP_RD and S_UP_CMP while it climbs, and a remove
// passes S_DN_LAST and S_DN_LOAD and then alternates S_DN_RD and S_DN_CMP
// while it sinks; each ends in S_FINISH, which loads the result register.
// A remove that empties the heap, a dropped insert and a remove on empty go
// from the queue pop straight to S_FINISH. Each level costs one registered
// RAM read plus one compare-and-write.
// Reset (arst_n) empties the heap at once; RAM contents need no clearing.
// in_stall rises only when the command queue is full; a stalled output beat
// holds in the result register while the back end finishes its current work.
//
module binary_max_heap_queue_unit
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DATA_W-1:0]  removed_value,
	output logic signed [DATA_W-1:0]  top_value,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic [STATUS_W-1:0]       status
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	item_t head;

	// stall the input beat only while the command queue has no room
	assign in_stall = q_full;

	// front: accept and classify full / empty cases ahead of the heap work
	bmhq_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.value     (value),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// queue: decouple the input side from the sift sequencer
	bmhq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	// back end: sift over the heap RAM, drive the result beat
	bmhq_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.removed_value (removed_value),
		.top_value     (top_value),
		.count         (count),
		.is_empty      (is_empty),
		.status        (status)
	);

endmodule
